// ===== rtl/gtb_pkg.sv =====
// ----------------------------------------------------------------------------
// gtb_pkg
// Shared constants, codes and types for the glyph text blitter.
// ----------------------------------------------------------------------------
package gtb_pkg;

  localparam int LINE_STRIDE = 320;
  localparam int GLYPH_ROWS  = 12;
  localparam int FONT_WORDS  = 4096;

  localparam int FONT_AW   = $clog2(FONT_WORDS);
  localparam int ROW_W     = $clog2(GLYPH_ROWS + 1);
  localparam int ADDR_W    = 24;
  localparam int COLOR_W   = 16;
  localparam int PAL_DEPTH = 16;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);
  localparam int PIXELS    = 8;
  localparam int FONT_W    = 32;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] CMD_FONT   = 2'd0;
  localparam logic [1:0] CMD_PAL    = 2'd1;
  localparam logic [1:0] CMD_CURSOR = 2'd2;
  localparam logic [1:0] CMD_DRAW   = 2'd3;

  localparam logic CFG_MAX_CHAR   = 1'b0;
  localparam logic CFG_FRAME_BASE = 1'b1;

  localparam logic [7:0] FALLBACK_CODE    = 8'h3B;
  localparam logic [7:0] FIRST_GLYPH_CODE = 8'h0F;
  localparam logic [7:0] CODE_SPACE       = 8'd1;
  localparam logic [7:0] CODE_NEWLINE     = 8'd10;

  localparam logic [ADDR_W-1:0] SPACE_ADVANCE = ADDR_W'(3);
  localparam logic [ADDR_W-1:0] GLYPH_ADVANCE = ADDR_W'(9);
  localparam logic [15:0]       LINE_ADVANCE  = 16'h000D;

  typedef struct packed {
    logic [ADDR_W-1:0]      row_address;
    logic [PIXELS-1:0]      write_mask;
    logic [4*COLOR_W-1:0]   pixels_left;
    logic [4*COLOR_W-1:0]   pixels_right;
    logic                   last_row;
  } row_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } pp_status_t;

endpackage

// ===== rtl/gtb_ram.sv =====
// ----------------------------------------------------------------------------
// gtb_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module gtb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gtb_pixel_path.sv =====
// ----------------------------------------------------------------------------
// gtb_pixel_path
// Two-stage row path: font word in, eight palette lookups, row out.
// ----------------------------------------------------------------------------
module gtb_pixel_path
  import gtb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   issue,
  input  logic [ADDR_W-1:0]      issue_addr,
  input  logic                   issue_last,
  input  logic [FONT_W-1:0]      font_word,
  input  logic                   pal_we,
  input  logic [PAL_AW-1:0]      pal_waddr,
  input  logic [COLOR_W-1:0]     pal_wdata,
  output logic                   row_valid,
  output row_t                   row,
  output pp_status_t             status
);

  logic                s1_valid;
  logic [ADDR_W-1:0]   s1_addr;
  logic                s1_last;
  logic                s2_valid;
  logic [ADDR_W-1:0]   s2_addr;
  logic                s2_last;
  logic [PIXELS-1:0]   s2_mask;
  logic [COLOR_W-1:0]  pal_rdata [PIXELS];
  logic [COLOR_W-1:0]  color [PIXELS];

  // one palette copy per pixel lane
  for (genvar p = 0; p < PIXELS; p++) begin : g_lane
    gtb_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PAL_DEPTH)
    ) u_pal (
      .clk   (clk),
      .we    (pal_we),
      .waddr (pal_waddr),
      .wdata (pal_wdata),
      .raddr (font_word[FONT_W-1-4*p -: 4]),
      .rdata (pal_rdata[p])
    );

    assign color[p] = s2_mask[p] ? pal_rdata[p] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
    s1_addr <= issue_addr;
    s1_last <= issue_last;
    s2_addr <= s1_addr;
    s2_last <= s1_last;
    for (int p = 0; p < PIXELS; p++) begin
      s2_mask[p] <= |font_word[FONT_W-1-4*p -: 4];
    end
  end

  assign row_valid        = s2_valid;
  assign row.row_address  = s2_addr;
  assign row.write_mask   = s2_mask;
  assign row.pixels_left  = {color[3], color[2], color[1], color[0]};
  assign row.pixels_right = {color[7], color[6], color[5], color[4]};
  assign row.last_row     = s2_last;

  assign status.s1_valid = s1_valid;
  assign status.s2_valid = s2_valid;

endmodule

// ===== rtl/gtb_out_fifo.sv =====
// ----------------------------------------------------------------------------
// gtb_out_fifo
// Small row queue between the pixel path and the output channel.
// ----------------------------------------------------------------------------
module gtb_out_fifo
  import gtb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  row_t               push_row,
  input  logic               pop,
  output row_t               head,
  output logic               not_empty,
  output logic [FIFO_CW-1:0] count
);

  row_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FIFO_CW'(push) - FIFO_CW'(pop);
    end
    if (push) begin
      entries[wr_ptr] <= push_row;
    end
  end

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);

endmodule

// ===== rtl/glyph_text_blitter.sv =====
// ----------------------------------------------------------------------------
// glyph_text_blitter
// Character generator: loads font and palette, tracks the text cursor and
// draws glyphs as a stream of masked 8-pixel row writes.
// ----------------------------------------------------------------------------
// Loads, cursor moves, space and newline finish in the idle state.
// Draw: one row a cycle from the font RAM read port while queue credit allows,
// through font read and palette read; next item taken once all 12 rows issued.
// Output stalls beyond the 4-row queue hold back row issue.
// Reset clears cursor, registers and queue; font and palette hold garbage
// until loaded, and no clearing pass is run.
module glyph_text_blitter
  import gtb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [ADDR_W-1:0]  cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [11:0]        table_index,
  input  logic [31:0]        table_data,
  input  logic signed [15:0] cursor_x,
  input  logic signed [15:0] cursor_y,
  input  logic [7:0]         char_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ADDR_W-1:0]  row_address,
  output logic [7:0]         write_mask,
  output logic [63:0]        pixels_left,
  output logic [63:0]        pixels_right,
  output logic               last_row
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DRAW = 1'b1;

  logic               state;
  logic [7:0]         max_char_code;
  logic [ADDR_W-1:0]  frame_base;
  logic [ADDR_W-1:0]  draw_pointer;
  logic [15:0]        line_start_x;
  logic [15:0]        line_y;
  logic [ROW_W-1:0]   row;
  logic [FONT_AW-1:0] font_addr;
  logic [ADDR_W-1:0]  row_addr;

  logic               in_acc;
  logic               issue;
  logic               issue_last;
  logic [FONT_W-1:0]  font_word;
  logic               row_valid;
  row_t               new_row;
  row_t               head;
  pp_status_t         pp_status;
  logic [FIFO_CW-1:0] fifo_count;
  logic [FIFO_CW:0]   used;

  logic [15:0]        place_x;
  logic [15:0]        place_y;
  logic [ADDR_W-1:0]  y_term;
  logic [ADDR_W-1:0]  place_ptr;
  logic [7:0]         code_sel;
  logic [7:0]         glyph;
  logic [FONT_AW-1:0] base_word;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE) || pp_status.s1_valid;
  assign in_acc    = in_valid && !in_stall;

  assign place_x   = (cmd == CMD_CURSOR) ? cursor_x : line_start_x;
  assign place_y   = (cmd == CMD_CURSOR) ? cursor_y : line_y + LINE_ADVANCE;
  assign y_term    = ADDR_W'({{(ADDR_W-16){place_y[15]}}, place_y}
                             * ADDR_W'(LINE_STRIDE));
  assign place_ptr = frame_base + {{(ADDR_W-16){place_x[15]}}, place_x} + y_term;

  assign code_sel  = (char_code < FIRST_GLYPH_CODE || char_code > max_char_code)
                     ? FALLBACK_CODE : char_code;
  assign glyph     = code_sel - FIRST_GLYPH_CODE;
  assign base_word = FONT_AW'(32'(glyph[7:3]) * 32'(8 * GLYPH_ROWS) + 32'(glyph[2:0]));

  assign used       = (FIFO_CW+1)'(fifo_count)
                      + (FIFO_CW+1)'(pp_status.s1_valid)
                      + (FIFO_CW+1)'(pp_status.s2_valid);
  assign issue      = (state == ST_DRAW) && (used < (FIFO_CW+1)'(FIFO_DEPTH));
  assign issue_last = (row == ROW_W'(GLYPH_ROWS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      max_char_code <= 8'hFF;
      frame_base    <= '0;
      draw_pointer  <= '0;
      line_start_x  <= '0;
      line_y        <= '0;
      row           <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MAX_CHAR:   max_char_code <= cfg_data[7:0];
          CFG_FRAME_BASE: frame_base    <= cfg_data;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc && cmd == CMD_CURSOR) begin
            line_start_x <= place_x;
            line_y       <= place_y;
            draw_pointer <= place_ptr;
          end else if (in_acc && cmd == CMD_DRAW) begin
            if (char_code == CODE_SPACE) begin
              draw_pointer <= draw_pointer + SPACE_ADVANCE;
            end else if (char_code == CODE_NEWLINE) begin
              line_y       <= place_y;
              draw_pointer <= place_ptr;
            end else begin
              state     <= ST_DRAW;
              row       <= '0;
              font_addr <= base_word;
              row_addr  <= draw_pointer;
            end
          end
        end
        ST_DRAW: begin
          if (issue) begin
            row       <= row + 1'b1;
            font_addr <= font_addr + FONT_AW'(8);
            row_addr  <= row_addr + ADDR_W'(LINE_STRIDE);
            if (issue_last) begin
              state        <= ST_IDLE;
              draw_pointer <= draw_pointer + GLYPH_ADVANCE;
            end
          end
        end
      endcase
    end
  end

  gtb_ram #(
    .WIDTH (FONT_W),
    .DEPTH (FONT_WORDS)
  ) u_font (
    .clk   (clk),
    .we    (in_acc && cmd == CMD_FONT),
    .waddr (FONT_AW'(table_index)),
    .wdata (table_data),
    .raddr (font_addr),
    .rdata (font_word)
  );

  gtb_pixel_path u_pixel_path (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .issue_addr (row_addr),
    .issue_last (issue_last),
    .font_word  (font_word),
    .pal_we     (in_acc && cmd == CMD_PAL),
    .pal_waddr  (table_index[PAL_AW-1:0]),
    .pal_wdata  (table_data[COLOR_W-1:0]),
    .row_valid  (row_valid),
    .row        (new_row),
    .status     (pp_status)
  );

  gtb_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (row_valid),
    .push_row  (new_row),
    .pop       (out_valid && !out_stall),
    .head      (head),
    .not_empty (out_valid),
    .count     (fifo_count)
  );

  assign row_address  = head.row_address;
  assign write_mask   = head.write_mask;
  assign pixels_left  = head.pixels_left;
  assign pixels_right = head.pixels_right;
  assign last_row     = head.last_row;

  a_credit: assert property (@(posedge clk) disable iff (rst)
    used <= (FIFO_CW+1)'(FIFO_DEPTH))
    else $error("row queue credit exceeded");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    row_valid |-> (fifo_count < FIFO_CW'(FIFO_DEPTH)))
    else $error("row pushed into full queue");

  a_last_ends_draw: assert property (@(posedge clk) disable iff (rst)
    issue && issue_last |=> state == ST_IDLE && pp_status.s1_valid)
    else $error("draw did not end after last row");

  a_no_take_in_flight: assert property (@(posedge clk) disable iff (rst)
    pp_status.s1_valid |-> in_stall)
    else $error("item taken with palette read in flight");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for glyph_text_blitter. A scoreboard mirrors the font,
// the palette and the cursor state and expands every accepted glyph draw into
// its row writes. Each row leaving the block is checked against the oldest
// of these. Stimulus is a directed opening and then random items over several
// register settings, with random idling on both channels and an output
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench
  import gtb_pkg::*;
;

  typedef struct {
    logic [1:0]  cmd;
    logic [11:0] table_index;
    logic [31:0] table_data;
    logic [15:0] cursor_x;
    logic [15:0] cursor_y;
    logic [7:0]  char_code;
  } blit_item_t;

  class row_scoreboard;
    row_t              rows_due[$];
    logic [31:0]       font_mem [FONT_WORDS];
    bit                font_loaded [FONT_WORDS];
    logic [15:0]       pal_mem [PAL_DEPTH];
    logic [ADDR_W-1:0] pen;
    logic [15:0]       home_x;
    logic [15:0]       line_row;
    logic [7:0]        top_code;
    logic [ADDR_W-1:0] frame_origin;
    int unsigned       mismatches;
    int unsigned       rows_checked;

    function new();
      for (int i = 0; i < FONT_WORDS; i++) begin
        font_mem[i]    = '0;
        font_loaded[i] = 1'b0;
      end
      for (int i = 0; i < PAL_DEPTH; i++) pal_mem[i] = '0;
      pen          = '0;
      home_x       = '0;
      line_row     = '0;
      top_code     = 8'd255;
      frame_origin = '0;
      mismatches   = 0;
      rows_checked = 0;
    endfunction

    function void set_register(logic idx, logic [ADDR_W-1:0] value);
      if (idx == CFG_MAX_CHAR) begin
        top_code = value[7:0];
      end else begin
        frame_origin = value;
      end
    endfunction

    function logic [7:0] glyph_code(logic [7:0] code);
      if (code < FIRST_GLYPH_CODE || code > top_code) return FALLBACK_CODE;
      return code;
    endfunction

    function int word_index(logic [7:0] code, int r);
      int g;
      g = int'(code) - int'(FIRST_GLYPH_CODE);
      return ((g >> 3) * 8 * GLYPH_ROWS + (g & 7) + 8 * r) % FONT_WORDS;
    endfunction

    function void place_pen(logic [15:0] x, logic [15:0] y);
      int sx;
      int sy;
      int t;
      sx       = $signed(x);
      sy       = $signed(y);
      home_x   = x;
      line_row = y;
      t        = int'(frame_origin) + sx + sy * LINE_STRIDE;
      pen      = ADDR_W'(t);
    endfunction

    function void predict_rows(logic [7:0] code);
      row_t        row;
      logic [31:0] word;
      logic [3:0]  nib;
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        word = font_mem[word_index(code, r)];
        row  = '0;
        for (int p = 0; p < PIXELS; p++) begin
          nib = word[31-4*p -: 4];
          if (nib != 4'd0) begin
            row.write_mask[p] = 1'b1;
            if (p < 4) row.pixels_left[16*p +: 16] = pal_mem[nib];
            else row.pixels_right[16*(p-4) +: 16] = pal_mem[nib];
          end
        end
        row.row_address = ADDR_W'(pen + r * LINE_STRIDE);
        row.last_row    = (r == GLYPH_ROWS - 1);
        rows_due.push_back(row);
      end
      pen = pen + GLYPH_ADVANCE;
    endfunction

    function void accept_item(blit_item_t it);
      case (it.cmd)
        CMD_FONT: begin
          font_mem[it.table_index % FONT_WORDS]    = it.table_data;
          font_loaded[it.table_index % FONT_WORDS] = 1'b1;
        end
        CMD_PAL: pal_mem[it.table_index[PAL_AW-1:0]] = it.table_data[15:0];
        CMD_CURSOR: place_pen(it.cursor_x, it.cursor_y);
        default: begin
          if (it.char_code == CODE_SPACE) begin
            pen = pen + SPACE_ADVANCE;
          end else if (it.char_code == CODE_NEWLINE) begin
            place_pen(home_x, 16'(line_row + LINE_ADVANCE));
          end else begin
            predict_rows(glyph_code(it.char_code));
          end
        end
      endcase
    endfunction

    function void check_row(row_t got);
      row_t want;
      if (rows_due.size() == 0) begin
        $error("row write with none due: address %h", got.row_address);
        mismatches++;
        return;
      end
      want = rows_due.pop_front();
      rows_checked++;
      if (got.row_address !== want.row_address) begin
        $error("row_address expected %h actual %h", want.row_address, got.row_address);
        mismatches++;
      end
      if (got.write_mask !== want.write_mask) begin
        $error("write_mask expected %h actual %h", want.write_mask, got.write_mask);
        mismatches++;
      end
      if (got.pixels_left !== want.pixels_left) begin
        $error("pixels_left expected %h actual %h", want.pixels_left, got.pixels_left);
        mismatches++;
      end
      if (got.pixels_right !== want.pixels_right) begin
        $error("pixels_right expected %h actual %h", want.pixels_right, got.pixels_right);
        mismatches++;
      end
      if (got.last_row !== want.last_row) begin
        $error("last_row expected %b actual %b", want.last_row, got.last_row);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [ADDR_W-1:0]  cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         cmd;
  logic [11:0]        table_index;
  logic [31:0]        table_data;
  logic signed [15:0] cursor_x;
  logic signed [15:0] cursor_y;
  logic [7:0]         char_code;
  logic               out_valid;
  logic               out_stall;
  logic [ADDR_W-1:0]  row_address;
  logic [7:0]         write_mask;
  logic [63:0]        pixels_left;
  logic [63:0]        pixels_right;
  logic               last_row;

  row_scoreboard board;
  bit            idle_on;
  bit            long_hold_req;
  int unsigned   items_sent;
  int unsigned   draws_sent;
  int unsigned   settings_used;
  logic [7:0]    code_pool[$];

  glyph_text_blitter uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .table_index  (table_index),
    .table_data   (table_data),
    .cursor_x     (cursor_x),
    .cursor_y     (cursor_y),
    .char_code    (char_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .row_address  (row_address),
    .write_mask   (write_mask),
    .pixels_left  (pixels_left),
    .pixels_right (pixels_right),
    .last_row     (last_row)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

  // receiver: random stall bursts, long hold-off on request, row checking
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        board.check_row('{row_address, write_mask, pixels_left, pixels_right, last_row});
      end
      if (long_hold_req) begin
        hold_left     = 200;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic blit_item_t noise_item();
    blit_item_t it;
    it.cmd         = 2'($urandom_range(0, 3));
    it.table_index = 12'($urandom);
    it.table_data  = $urandom;
    it.cursor_x    = 16'($urandom);
    it.cursor_y    = 16'($urandom);
    it.char_code   = 8'($urandom);
    return it;
  endfunction

  function automatic logic [31:0] glyph_word();
    logic [31:0] w;
    w = $urandom;
    for (int n = 0; n < 8; n++) begin
      if ($urandom_range(0, 3) == 0) w[4*n +: 4] = 4'd0;
    end
    return w;
  endfunction

  task automatic send_item(blit_item_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= it.cmd;
    table_index <= it.table_index;
    table_data  <= it.table_data;
    cursor_x    <= it.cursor_x;
    cursor_y    <= it.cursor_y;
    char_code   <= it.char_code;
    do @(posedge clk); while (in_stall);
    board.accept_item(it);
    items_sent++;
  endtask

  task automatic send_font(logic [11:0] idx, logic [31:0] data);
    blit_item_t it;
    it             = noise_item();
    it.cmd         = CMD_FONT;
    it.table_index = idx;
    it.table_data  = data;
    send_item(it);
  endtask

  task automatic send_palette(logic [11:0] idx, logic [15:0] color);
    blit_item_t it;
    it             = noise_item();
    it.cmd         = CMD_PAL;
    it.table_index = idx;
    it.table_data  = {16'($urandom), color};
    send_item(it);
  endtask

  task automatic send_cursor(logic [15:0] x, logic [15:0] y);
    blit_item_t it;
    it          = noise_item();
    it.cmd      = CMD_CURSOR;
    it.cursor_x = x;
    it.cursor_y = y;
    send_item(it);
  endtask

  // loads any missing font words of the glyph first, then draws
  task automatic draw_char(logic [7:0] code);
    blit_item_t  it;
    logic [7:0]  g;
    int          idx;
    if (code != CODE_SPACE && code != CODE_NEWLINE) begin
      g = board.glyph_code(code);
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        idx = board.word_index(g, r);
        if (!board.font_loaded[idx]) send_font(12'(idx), glyph_word());
      end
      draws_sent++;
      if (code_pool.size() < 40) code_pool.push_back(code);
    end
    it           = noise_item();
    it.cmd       = CMD_DRAW;
    it.char_code = code;
    send_item(it);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.rows_due.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_registers(logic [7:0] top, logic [ADDR_W-1:0] origin);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAX_CHAR;
    cfg_data  <= ADDR_W'(top);
    do @(posedge clk); while (!cfg_ready);
    board.set_register(CFG_MAX_CHAR, ADDR_W'(top));
    cfg_index <= CFG_FRAME_BASE;
    cfg_data  <= origin;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(CFG_FRAME_BASE, origin);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_step();
    blit_item_t it;
    int         pick;
    pick = $urandom_range(0, 99);
    it   = noise_item();
    if (pick < 50) begin
      if (code_pool.size() == 0 || $urandom_range(0, 6) == 0) begin
        draw_char(8'($urandom_range(0, 255)));
      end else begin
        draw_char(code_pool[$urandom_range(0, code_pool.size() - 1)]);
      end
    end else if (pick < 60) begin
      it.cmd       = CMD_DRAW;
      it.char_code = CODE_SPACE;
      send_item(it);
    end else if (pick < 68) begin
      it.cmd       = CMD_DRAW;
      it.char_code = CODE_NEWLINE;
      send_item(it);
    end else if (pick < 78) begin
      it.cmd = CMD_CURSOR;
      send_item(it);
    end else if (pick < 88) begin
      it.cmd = CMD_PAL;
      send_item(it);
    end else begin
      it.cmd = CMD_FONT;
      send_item(it);
    end
  endtask

  task automatic run_random(int unsigned upto);
    while (items_sent < upto) random_step();
  endtask

  task automatic directed_opening();
    logic [31:0] w;
    for (int i = 0; i < PAL_DEPTH; i++) begin
      send_palette((i == 0) ? 12'hFF0 : 12'(i),
                   (i == 1) ? 16'hFFFF : (i == 2) ? 16'h0000 : 16'($urandom));
    end
    send_font(12'hFFF, 32'hFFFF_FFFF);
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      case (r)
        0:       w = 32'h0000_0000;
        1:       w = 32'hFFFF_FFFF;
        2:       w = 32'h1234_5678;
        3:       w = 32'h9ABC_DEF0;
        default: w = glyph_word();
      endcase
      send_font(12'(board.word_index(FIRST_GLYPH_CODE, r)), w);
    end
    send_cursor(16'h0000, 16'h0000);
    draw_char(FIRST_GLYPH_CODE);
    draw_char(8'd14);
    draw_char(8'd0);
    draw_char(8'd255);
    draw_char(CODE_SPACE);
    draw_char(CODE_NEWLINE);
    send_cursor(16'h8000, 16'h8000);
    draw_char(FALLBACK_CODE);
    send_cursor(16'h7FFF, 16'h7FFF);
    draw_char(8'd128);
    draw_char(CODE_NEWLINE);
    draw_char(8'd16);
  endtask

  initial begin
    int unsigned wait_cycles;
    board         = new();
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    items_sent    = 0;
    draws_sent    = 0;
    settings_used = 1;
    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_MAX_CHAR;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    cmd         <= CMD_FONT;
    table_index <= '0;
    table_data  <= '0;
    cursor_x    <= '0;
    cursor_y    <= '0;
    char_code   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_opening();
    wait_drain();

    // every code but the controls falls back; top of address space
    write_registers(8'd0, 24'hFF_FFFF);
    send_cursor(16'($urandom), 16'($urandom));
    run_random(150);
    wait_drain();

    // output held off while draws keep coming, so the input backs up
    write_registers(8'd255, 24'h00_0000);
    long_hold_req = 1'b1;
    for (int i = 0; i < 10; i++) draw_char(code_pool[$urandom_range(0, code_pool.size() - 1)]);
    run_random(230);
    wait_drain();

    write_registers(8'($urandom), 24'($urandom));
    run_random(270);
    wait_drain();
    run_random(310);
    wait_drain();

    idle_on = 1'b0;
    write_registers(8'($urandom_range(FIRST_GLYPH_CODE, 255)), 24'($urandom));
    run_random(370);

    in_valid <= 1'b0;
    wait_cycles = 0;
    do begin
      @(posedge clk);
      wait_cycles++;
    end while (board.rows_due.size() != 0 && wait_cycles < 5000);
    repeat (30) @(posedge clk);
    if (board.rows_due.size() != 0) begin
      $error("%0d row writes never arrived", board.rows_due.size());
      board.mismatches++;
    end

    $display("Run: %0d items accepted, %0d of them glyph draws, under %0d register settings",
             items_sent, draws_sent, settings_used);
    $display("Run: %0d row writes checked, %0d mismatches", board.rows_checked,
             board.mismatches);
    if (board.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
